/* src/lrt_pkg.sv */
// ----------------------------------------------------------------------------
// lrt_pkg
// shared constants and opcodes of the loop region tracker
// ----------------------------------------------------------------------------
package lrt_pkg;

  // table geometry
  localparam int unsigned MAX_REGIONS = 16;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned ENTRY_W     = 2 * POS_W;

  // request opcodes
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd1;
  localparam logic [OP_W-1:0] OP_EXIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

endpackage

/* src/loop_region_tracker.sv */
// ----------------------------------------------------------------------------
// loop_region_tracker
// playback loop region tracker: region table in ram, scanned per position
// update, with entered / cancelled bits and one active region
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        request    in_valid_i / in_stall_o    opcode, new_pos, slot, start_pos, end_pos
//  out       result     out_valid_o / out_stall_i  jump, target, exit, status fields
//  cfg       write      cfg_we_i                   cfg_wdata_i (region_count)
//
//  a position update reads each used slot from the ram in turn and checks each
//  entry once its registered read data is back, then closes the scan, reads the
//  active slot and runs the final step; every other opcode reads the active slot
//  and runs the final step, a region write first writing the table entry
//  one request is in flight at a time; a finished result waits in the output
//  register while the next request is taken, and stalls only the final step
//  reset clears entered / cancelled bits, active state and region_count;
//  the region table itself is left as is
// ----------------------------------------------------------------------------
module loop_region_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [lrt_pkg::CFG_W-1:0]      cfg_wdata_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lrt_pkg::OP_W-1:0]       opcode_i,
  input  logic [lrt_pkg::POS_W-1:0]      new_pos_i,
  input  logic [lrt_pkg::SLOT_W-1:0]     slot_i,
  input  logic [lrt_pkg::POS_W-1:0]      start_pos_i,
  input  logic [lrt_pkg::POS_W-1:0]      end_pos_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           jump_valid_o,
  output logic [lrt_pkg::POS_W-1:0]      target_pos_o,
  output logic                           exit_valid_o,
  output logic                           activated_o,
  output logic                           had_active_o,
  output logic                           active_valid_o,
  output logic [lrt_pkg::SLOT_W-1:0]     active_slot_o,
  output logic [lrt_pkg::POS_W-1:0]      active_start_o,
  output logic [lrt_pkg::POS_W-1:0]      active_end_o
);

  localparam int unsigned POS_W   = lrt_pkg::POS_W;
  localparam int unsigned IDX_W   = lrt_pkg::IDX_W;
  localparam int unsigned CNT_W   = lrt_pkg::CNT_W;
  localparam int unsigned NREG    = lrt_pkg::MAX_REGIONS;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_RDACT = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  logic [2:0] state_q, state_d;

  // captured request
  logic [lrt_pkg::OP_W-1:0]   op_q;
  logic [POS_W-1:0]           pos_q;
  logic [lrt_pkg::SLOT_W-1:0] slot_q;
  logic [POS_W-1:0]           wstart_q, wend_q;
  logic                       take;

  // configuration and tracking state
  logic [lrt_pkg::CFG_W-1:0]  count_q;
  logic [CNT_W-1:0]           used;
  logic [CNT_W-1:0]           n_q, n_d;
  logic [NREG-1:0]            entered_q, entered_d;
  logic [NREG-1:0]            cancelled_q, cancelled_d;
  logic                       active_q, active_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic                       act_new_q, act_new_d;

  // scan pipeline
  logic [CNT_W-1:0]           scan_cnt_q, scan_cnt_d;
  logic                       pv_q, pv_d;
  logic [IDX_W-1:0]           pidx_q, pidx_d;
  logic                       found_q, found_d;
  logic [IDX_W-1:0]           fidx_q, fidx_d;
  logic                       issue;

  // table ram
  logic                          ram_we, ram_re;
  logic [IDX_W-1:0]              ram_waddr, ram_raddr;
  logic [lrt_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [POS_W-1:0]              rd_start, rd_end;
  logic                          hit;

  // result
  logic                          out_valid_q, out_valid_d;
  logic                          load;
  logic                          res_jump, res_exit, res_act, res_had, res_av;
  logic [POS_W-1:0]              res_target, res_start, res_end;
  logic [lrt_pkg::SLOT_W-1:0]    res_slot;
  logic                          idx_lt_n, present, drop;

  logic                          jump_q, exit_q, act_q, had_q, av_q;
  logic [POS_W-1:0]              target_q, astart_q, aend_q;
  logic [lrt_pkg::SLOT_W-1:0]    aslot_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && !in_stall_o;

  // counts above the table size act as the table size
  assign used = (count_q > lrt_pkg::CFG_W'(NREG)) ? CNT_W'(NREG) : CNT_W'(count_q);

  assign issue = (state_q == ST_SCAN) && (scan_cnt_q < n_q);

  assign ram_we    = (state_q == ST_WRITE);
  assign ram_waddr = IDX_W'(slot_q);
  assign ram_re    = issue || (state_q == ST_RDACT);
  assign ram_raddr = (state_q == ST_RDACT) ? idx_q : scan_cnt_q[IDX_W-1:0];

  lrt_ram #(
    .WIDTH (lrt_pkg::ENTRY_W),
    .DEPTH (NREG)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({wstart_q, wend_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_start = ram_rdata[2*POS_W-1:POS_W];
  assign rd_end   = ram_rdata[POS_W-1:0];

  // start inclusive, end exclusive; an empty region never hits
  assign hit = (pos_q >= rd_start) && (pos_q < rd_end);

  // final step terms, taken with the active slot entry on the read port
  assign idx_lt_n = (CNT_W'(idx_q) < n_q);
  assign present  = active_q && idx_lt_n;
  assign drop     = ((op_q == lrt_pkg::OP_CANCEL) || (op_q == lrt_pkg::OP_EXIT)) && active_q;
  assign load     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    res_jump   = (op_q == lrt_pkg::OP_UPDATE) && active_q && !act_new_q && idx_lt_n
                 && (pos_q >= rd_end);
    res_exit   = (op_q == lrt_pkg::OP_EXIT) && present;
    res_act    = act_new_q;
    res_had    = drop;
    res_target = res_jump ? rd_start : (res_exit ? rd_end : '0);
    if (drop) begin
      res_av    = 1'b0;
      res_slot  = '0;
      res_start = '0;
      res_end   = '0;
    end else begin
      res_av    = active_q;
      res_slot  = active_q ? lrt_pkg::SLOT_W'(idx_q) : '0;
      res_start = present ? rd_start : '0;
      res_end   = present ? rd_end : '0;
    end
  end

  // sequencer and tracking state
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    entered_d   = entered_q;
    cancelled_d = cancelled_q;
    active_d    = active_q;
    idx_d       = idx_q;
    act_new_d   = act_new_q;
    scan_cnt_d  = scan_cnt_q;
    pv_d        = pv_q;
    pidx_d      = pidx_q;
    found_d     = found_q;
    fidx_d      = fidx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          n_d        = used;
          scan_cnt_d = '0;
          pv_d       = 1'b0;
          found_d    = 1'b0;
          act_new_d  = 1'b0;
          case (opcode_i)
            lrt_pkg::OP_UPDATE: state_d = ST_SCAN;
            lrt_pkg::OP_WRITE:  state_d = ST_WRITE;
            lrt_pkg::OP_CLEAR: begin
              entered_d   = '0;
              cancelled_d = '0;
              active_d    = 1'b0;
              idx_d       = '0;
              state_d     = ST_RDACT;
            end
            default:            state_d = ST_RDACT;
          endcase
        end
      end
      ST_SCAN: begin
        // one slot read per cycle, checked in the following cycle
        pv_d   = issue;
        pidx_d = scan_cnt_q[IDX_W-1:0];
        if (issue) begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (pv_q && hit) begin
          entered_d[pidx_q] = 1'b1;
          // a containing slot is entered now, so of its own bits only cancelled can block it
          if (!active_q && !found_q && !cancelled_q[pidx_q]) begin
            found_d = 1'b1;
            fidx_d  = pidx_q;
          end
        end
        if (!issue && !pv_q) begin
          if (!active_q && found_q) begin
            active_d  = 1'b1;
            idx_d     = fidx_q;
            act_new_d = 1'b1;
          end
          state_d = ST_RDACT;
        end
      end
      ST_WRITE: state_d = ST_RDACT;
      ST_RDACT: state_d = ST_EXEC;
      ST_EXEC: begin
        if (load) begin
          if (drop) begin
            cancelled_d[idx_q] = 1'b1;
            active_d           = 1'b0;
            idx_d              = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      entered_q   <= '0;
      cancelled_q <= '0;
      active_q    <= 1'b0;
      idx_q       <= '0;
      act_new_q   <= 1'b0;
      scan_cnt_q  <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      fidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      n_q         <= n_d;
      entered_q   <= entered_d;
      cancelled_q <= cancelled_d;
      active_q    <= active_d;
      idx_q       <= idx_d;
      act_new_q   <= act_new_d;
      scan_cnt_q  <= scan_cnt_d;
      pv_q        <= pv_d;
      pidx_q      <= pidx_d;
      found_q     <= found_d;
      fidx_q      <= fidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload capture
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q     <= opcode_i;
      pos_q    <= new_pos_i;
      slot_q   <= slot_i;
      wstart_q <= start_pos_i;
      wend_q   <= end_pos_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      jump_q   <= res_jump;
      target_q <= res_target;
      exit_q   <= res_exit;
      act_q    <= res_act;
      had_q    <= res_had;
      av_q     <= res_av;
      aslot_q  <= res_slot;
      astart_q <= res_start;
      aend_q   <= res_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign jump_valid_o   = jump_q;
  assign target_pos_o   = target_q;
  assign exit_valid_o   = exit_q;
  assign activated_o    = act_q;
  assign had_active_o   = had_q;
  assign active_valid_o = av_q;
  assign active_slot_o  = aslot_q;
  assign active_start_o = astart_q;
  assign active_end_o   = aend_q;

endmodule

/* src/lrt_ram.sv */
// ----------------------------------------------------------------------------
// lrt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lrt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lrt_checker.sv */
// ----------------------------------------------------------------------------
// lrt_checker
// port level checks of the loop region tracker, bound to the top level
// ----------------------------------------------------------------------------
module lrt_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lrt_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic [lrt_pkg::OP_W-1:0]       opcode_i,
  input  logic [lrt_pkg::POS_W-1:0]      new_pos_i,
  input  logic [lrt_pkg::SLOT_W-1:0]     slot_i,
  input  logic [lrt_pkg::POS_W-1:0]      start_pos_i,
  input  logic [lrt_pkg::POS_W-1:0]      end_pos_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic                           jump_valid_o,
  input  logic [lrt_pkg::POS_W-1:0]      target_pos_o,
  input  logic                           exit_valid_o,
  input  logic                           activated_o,
  input  logic                           had_active_o,
  input  logic                           active_valid_o,
  input  logic [lrt_pkg::SLOT_W-1:0]     active_slot_o,
  input  logic [lrt_pkg::POS_W-1:0]      active_start_o,
  input  logic [lrt_pkg::POS_W-1:0]      active_end_o
);

  // a taken request holds off the next one
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in flight");

  // no active region means no slot and no bounds
  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_valid_o |->
      active_slot_o == '0 && active_start_o == '0 && active_end_o == '0)
    else $error("status fields set without active region");

  // a jump keeps the region active and is not a drop
  a_jump_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && jump_valid_o |->
      active_valid_o && !exit_valid_o && !had_active_o && !activated_o)
    else $error("jump with inconsistent status");

  // an exit report always drops the active region
  a_exit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exit_valid_o |-> had_active_o && !active_valid_o && !activated_o)
    else $error("exit with inconsistent status");

  // activation leaves a region active and no target
  a_act_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && activated_o |-> active_valid_o && target_pos_o == '0)
    else $error("activation with inconsistent status");

endmodule

bind loop_region_tracker lrt_checker u_lrt_checker (.*);

/* test/loop_region_tracker_tb.sv */
// ----------------------------------------------------------------------------
// loop_region_tracker_tb
// self-checking bench for the loop region tracker: requests go in through the
// valid / stall channel, and a cycle-free tracker model in the bench predicts
// every status result. directed cases cover the region table bounds, jumps,
// exits, cancels, an active slot beyond region_count and unknown opcodes.
// random playback sessions with random gaps and stalls on both sides follow.
// ----------------------------------------------------------------------------
module loop_region_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REGIONS = lrt_pkg::MAX_REGIONS;
  localparam int unsigned POS_W       = lrt_pkg::POS_W;
  localparam int unsigned CFG_W       = lrt_pkg::CFG_W;
  localparam int unsigned OP_W        = lrt_pkg::OP_W;
  localparam int unsigned SLOT_W      = lrt_pkg::SLOT_W;

  localparam logic [OP_W-1:0] OP_UPDATE = lrt_pkg::OP_UPDATE;
  localparam logic [OP_W-1:0] OP_CANCEL = lrt_pkg::OP_CANCEL;
  localparam logic [OP_W-1:0] OP_EXIT   = lrt_pkg::OP_EXIT;
  localparam logic [OP_W-1:0] OP_CLEAR  = lrt_pkg::OP_CLEAR;
  localparam logic [OP_W-1:0] OP_WRITE  = lrt_pkg::OP_WRITE;

  localparam int HALF_PERIOD  = 1;
  localparam int RESET_CYCLES = 9;
  // long enough to cover the longest update, so any late stray result shows
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int OP_CODES     = 1 << OP_W;
  localparam int MAX_REPORTS  = 10;
  localparam int SESSIONS     = 12;
  localparam int SESSION_LEN  = 40;

  // one request as it crosses the input channel
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  new_pos;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
  } region_req_t;

  // one status result, fields in port order
  typedef struct packed {
    logic              jump_valid;
    logic [POS_W-1:0]  target_pos;
    logic              exit_valid;
    logic              activated;
    logic              had_active;
    logic              active_valid;
    logic [SLOT_W-1:0] active_slot;
    logic [POS_W-1:0]  active_start;
    logic [POS_W-1:0]  active_end;
  } loop_status_t;

  // every input starts at a known level
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i    = '0;
  logic [POS_W-1:0]  new_pos_i   = '0;
  logic [SLOT_W-1:0] slot_i      = '0;
  logic [POS_W-1:0]  start_pos_i = '0;
  logic [POS_W-1:0]  end_pos_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              jump_valid_o;
  logic [POS_W-1:0]  target_pos_o;
  logic              exit_valid_o;
  logic              activated_o;
  logic              had_active_o;
  logic              active_valid_o;
  logic [SLOT_W-1:0] active_slot_o;
  logic [POS_W-1:0]  active_start_o;
  logic [POS_W-1:0]  active_end_o;

  // tracker state as the bench sees it
  logic [POS_W-1:0]       track_start [MAX_REGIONS];
  logic [POS_W-1:0]       track_end   [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] track_entered;
  logic [MAX_REGIONS-1:0] track_cancelled;
  logic                   track_active;
  logic [SLOT_W-1:0]      track_slot;
  logic [CFG_W-1:0]       track_count;

  loop_status_t status_pending [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  lead_gap       = 0;
  bit           gaps_on        = 1'b1;

  loop_region_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .new_pos_i     (new_pos_i),
    .slot_i        (slot_i),
    .start_pos_i   (start_pos_i),
    .end_pos_i     (end_pos_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .jump_valid_o  (jump_valid_o),
    .target_pos_o  (target_pos_o),
    .exit_valid_o  (exit_valid_o),
    .activated_o   (activated_o),
    .had_active_o  (had_active_o),
    .active_valid_o(active_valid_o),
    .active_slot_o (active_slot_o),
    .active_start_o(active_start_o),
    .active_end_o  (active_end_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("loop_region_tracker_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tracker model
  // ---------------------------------------------------------------------------

  // start inclusive, end exclusive; start not below end holds nothing
  function automatic bit in_region(int idx, logic [POS_W-1:0] pos);
    return pos >= track_start[idx] && pos < track_end[idx];
  endfunction

  function automatic void clear_tracking();
    track_entered   = '0;
    track_cancelled = '0;
    track_active    = 1'b0;
    track_slot      = '0;
  endfunction

  // applies one request to the tracker state and gives back its status
  function automatic loop_status_t advance_tracker(region_req_t r);
    loop_status_t s;
    int           used;
    int           i;
    bit           found;
    s     = '0;
    found = 1'b0;
    // counts above the table size behave as a full table
    used  = (int'(track_count) > MAX_REGIONS) ? MAX_REGIONS : int'(track_count);
    case (r.opcode)
      OP_UPDATE: begin
        for (i = 0; i < used; i++)
          if (in_region(i, r.new_pos)) track_entered[i] = 1'b1;
        if (track_active) begin
          // an active slot beyond the count never jumps
          if (int'(track_slot) < used && r.new_pos >= track_end[track_slot]) begin
            s.jump_valid = 1'b1;
            s.target_pos = track_start[track_slot];
          end
        end else begin
          // lowest entered, uncancelled slot holding the position wins
          for (i = 0; i < used; i++) begin
            if (!found && track_entered[i] && !track_cancelled[i] &&
                in_region(i, r.new_pos)) begin
              found        = 1'b1;
              track_active = 1'b1;
              track_slot   = SLOT_W'(i);
              s.activated  = 1'b1;
            end
          end
        end
      end
      OP_CANCEL, OP_EXIT: begin
        if (track_active) begin
          s.had_active = 1'b1;
          if (r.opcode == OP_EXIT && int'(track_slot) < used) begin
            s.exit_valid = 1'b1;
            s.target_pos = track_end[track_slot];
          end
          track_cancelled[track_slot] = 1'b1;
          track_active = 1'b0;
          track_slot   = '0;
        end
      end
      OP_CLEAR: clear_tracking();
      OP_WRITE: begin
        track_start[r.slot] = r.start_pos;
        track_end[r.slot]   = r.end_pos;
      end
      default: ;
    endcase
    s.active_valid = track_active;
    s.active_slot  = track_active ? track_slot : '0;
    if (track_active && int'(track_slot) < used) begin
      s.active_start = track_start[track_slot];
      s.active_end   = track_end[track_slot];
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // mostly back to back or short, now and then a long pause
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side stalls in bursts while gaps are on, with an open stretch before each
  always begin : result_stall
    int unsigned open_len;
    int unsigned hold_len;
    open_len = $urandom_range(1, 12);
    repeat (open_len) @(posedge clk_i);
    hold_len = gaps_on ? idle_len() : 0;
    if (hold_len > 0) begin
      out_stall_i <= 1'b1;
      repeat (hold_len) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // valid is left high after a request when the next one follows at once,
  // so it is only lowered in the step where a gap is chosen
  task automatic send_request(region_req_t r);
    repeat (lead_gap) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    opcode_i    <= r.opcode;
    new_pos_i   <= r.new_pos;
    slot_i      <= r.slot;
    start_pos_i <= r.start_pos;
    end_pos_i   <= r.end_pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    status_pending.push_back(advance_tracker(r));
    lead_gap = gaps_on ? idle_len() : 0;
    if (lead_gap > 0) in_valid_i <= 1'b0;
  endtask

  // fields the opcode does not use carry random noise
  function automatic region_req_t noise_req(logic [OP_W-1:0] op);
    region_req_t r;
    r.opcode    = op;
    r.new_pos   = $urandom;
    r.slot      = SLOT_W'($urandom);
    r.start_pos = $urandom;
    r.end_pos   = $urandom;
    return r;
  endfunction

  task automatic send_op(logic [OP_W-1:0] op);
    send_request(noise_req(op));
  endtask

  task automatic send_update(logic [POS_W-1:0] pos);
    region_req_t r;
    r         = noise_req(OP_UPDATE);
    r.new_pos = pos;
    send_request(r);
  endtask

  task automatic send_write(logic [SLOT_W-1:0] sl, logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    region_req_t r;
    r           = noise_req(OP_WRITE);
    r.slot      = sl;
    r.start_pos = lo;
    r.end_pos   = hi;
    send_request(r);
  endtask

  // region_count only changes once every result is back and the block is idle
  task automatic write_region_count(logic [CFG_W-1:0] value);
    if (lead_gap == 0) in_valid_i <= 1'b0;
    while (status_pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    track_count = value;
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s mismatch, got %h want %h", $realtime, name, got, want);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    loop_status_t got;
    loop_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {jump_valid_o, target_pos_o, exit_valid_o, activated_o, had_active_o,
             active_valid_o, active_slot_o, active_start_o, active_end_o};
      if (status_pending.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result with no request pending", $realtime);
        mismatch_count++;
      end else begin
        want = status_pending.pop_front();
        check_field("jump_valid", POS_W'(got.jump_valid), POS_W'(want.jump_valid));
        check_field("target_pos", got.target_pos, want.target_pos);
        check_field("exit_valid", POS_W'(got.exit_valid), POS_W'(want.exit_valid));
        check_field("activated", POS_W'(got.activated), POS_W'(want.activated));
        check_field("had_active", POS_W'(got.had_active), POS_W'(want.had_active));
        check_field("active_valid", POS_W'(got.active_valid), POS_W'(want.active_valid));
        check_field("active_slot", POS_W'(got.active_slot), POS_W'(want.active_slot));
        check_field("active_start", got.active_start, want.active_start);
        check_field("active_end", got.active_end, want.active_end);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // straight out of reset: no slots in use, nothing active to drop
  task automatic test_idle_ops();
    send_op(OP_CANCEL);
    send_op(OP_EXIT);
    send_update(32'h0000_1000);
    send_op(OP_CLEAR);
  endtask

  // fills every slot before any of them can be read
  task automatic test_table_load();
    int i;
    send_write(4'd0, 32'd1000, 32'd2000);
    send_write(4'd1, 32'd1500, 32'd2500);
    send_write(4'd2, 32'd3000, 32'd3000);           // empty, start equals end
    send_write(4'd3, 32'd4000, 32'd3500);           // inverted, holds nothing
    send_write(4'd4, 32'd0, 32'd10);                // starts at zero
    send_write(4'd5, 32'hFFFF_FFF0, 32'hFFFF_FFFF); // top of the range
    for (i = 6; i < MAX_REGIONS - 1; i++)
      send_write(SLOT_W'(i), $urandom, $urandom);
    send_write(4'd15, 32'd0, 32'hFFFF_FFFF);        // widest possible region
  endtask

  // activate, jump at and beyond the end, exit, then a second region
  task automatic test_jump_and_exit();
    write_region_count(5'd6);
    send_update(32'd1600);
    send_update(32'd1800);
    send_update(32'd2000);
    send_update(32'hFFFF_FFFF);
    send_op(OP_EXIT);
    send_update(32'd1600);  // slot 0 is cancelled now, slot 1 takes over
    send_op(OP_CANCEL);
    send_update(32'd1700);
    send_op(OP_CLEAR);
  endtask

  // active slot pushed out of range by a smaller count, then unknown opcodes
  task automatic test_absent_active();
    int op;
    send_update(32'd5);
    write_region_count(5'd3);
    send_update(32'd12);
    send_op(OP_CANCEL);
    write_region_count(5'd6);
    send_op(OP_CLEAR);
    send_update(32'd5);
    write_region_count(5'd3);
    send_op(OP_EXIT);
    for (op = int'(OP_WRITE) + 1; op < OP_CODES; op++)
      send_op(OP_W'(op));
  endtask

  // count at its top, at the table size and at zero
  task automatic test_count_extremes();
    write_region_count(5'd31);
    send_op(OP_CLEAR);
    send_update(32'hFFFF_FFF5);
    send_update(32'hFFFF_FFFF);
    send_op(OP_EXIT);
    write_region_count(5'd16);
    send_op(OP_CLEAR);
    send_update(32'd0);
    send_update(32'd10);
    send_op(OP_CANCEL);
    write_region_count(5'd0);
    send_update(32'd1500);
    send_op(OP_EXIT);
  endtask

  // region written inside the session window, now and then an empty one
  task automatic send_window_write(logic [POS_W-1:0] base, int unsigned span);
    int unsigned      used;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [SLOT_W-1:0] sl;
    used = (int'(track_count) > MAX_REGIONS) ? MAX_REGIONS : int'(track_count);
    sl   = (used > 0) ? SLOT_W'($urandom_range(0, used - 1))
                      : SLOT_W'($urandom_range(0, MAX_REGIONS - 1));
    lo   = base + POS_W'($urandom_range(0, span));
    if ($urandom_range(0, 7) == 0) hi = lo - POS_W'($urandom_range(0, 4));
    else hi = lo + POS_W'($urandom_range(1, span / 2));
    send_write(sl, lo, hi);
  endtask

  // playback sessions: regions placed in a window, then a cursor mostly
  // walking forward through it, with cancels, exits and clears mixed in
  task automatic test_random_sessions();
    logic [CFG_W-1:0] counts [6];
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] cursor;
    int unsigned      span;
    int unsigned      pick;
    int unsigned      sl;
    int               p;
    int               k;
    counts = '{5'd16, 5'd1, 5'd31, 5'd8, 5'd0, 5'd17};
    for (p = 0; p < SESSIONS; p++) begin
      gaps_on = (p % 6 != 0);  // two sessions run with no idling at all
      write_region_count((p < 6) ? counts[p] : CFG_W'($urandom_range(2, 16)));
      base   = $urandom;
      span   = $urandom_range(64, 8192);
      cursor = base;
      for (k = $urandom_range(2, 5); k > 0; k--)
        send_window_write(base, span);
      for (k = 0; k < SESSION_LEN; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          cursor = cursor + POS_W'($urandom_range(0, span / 16));
          send_update(cursor);
        end else if (pick < 55) begin
          // land right on a region edge
          sl = $urandom_range(0, MAX_REGIONS - 1);
          case ($urandom_range(0, 3))
            0:       cursor = track_start[sl];
            1:       cursor = track_end[sl];
            2:       cursor = track_end[sl] - 1'b1;
            default: cursor = track_start[sl] - 1'b1;
          endcase
          send_update(cursor);
        end else if (pick < 62) begin
          send_update(base + POS_W'($urandom_range(0, span)));
        end else if (pick < 65) begin
          send_update($urandom);
        end else if (pick < 73) begin
          send_op(OP_CANCEL);
        end else if (pick < 81) begin
          send_op(OP_EXIT);
        end else if (pick < 85) begin
          send_op(OP_CLEAR);
        end else if (pick < 93) begin
          send_window_write(base, span);
        end else if (pick < 96) begin
          send_write(SLOT_W'($urandom), $urandom, $urandom);
        end else begin
          send_op(OP_W'($urandom_range(int'(OP_WRITE) + 1, OP_CODES - 1)));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_tracking();
    track_count = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ops();
    test_table_load();
    test_jump_and_exit();
    test_absent_active();
    test_count_extremes();
    test_random_sessions();

    // let the last results drain, then watch a little longer for strays
    if (lead_gap == 0) in_valid_i <= 1'b0;
    while (status_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && status_pending.size() == 0) begin
      $display("loop_region_tracker_tb: PASS");
    end else begin
      $display("loop_region_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule
